// ----- hw/rtl/ldf_pkg.sv -----
// Package for the log packet deframer: frame layout constants, register
// indexes and the result item type. No dependencies.
package ldf_pkg;

    localparam int unsigned HEADER_LEN = 5;
    localparam int unsigned POS_W      = 17;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 1;

    localparam logic [POS_W-1:0] POS_SYNC_FIRST  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TYPE        = POS_W'(2);
    localparam logic [POS_W-1:0] POS_LEN_LOW     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_LEN_HIGH    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HEADER_END  = POS_W'(HEADER_LEN);

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = CFG_IDX_W'(1);

    typedef struct packed {
        logic              payload_valid;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_index;
        logic [BYTE_W-1:0] frame_type;
        logic [LEN_W-1:0]  frame_length;
        logic              frame_good;
        logic              frame_bad;
    } ldf_result_t;

endpackage

// ----- hw/rtl/log_packet_deframer.sv -----
// Log packet deframer top level: byte-serial frame parser with Fletcher-8
// check and a result buffer. Depends on ldf_pkg, ldf_parser, ldf_out_buf.
//
// Input channel: in_valid / in_stall with rx_byte, one byte per item.
// Output channel: out_valid / out_stall with one result item per input byte:
// payload pass-through (payload_valid, payload_byte, payload_index), the
// current frame_type and frame_length, and a frame_good / frame_bad verdict
// on the check bytes.
// Configuration: cfg_we writes cfg_data into the register chosen by
// cfg_index (0: first sync byte, 1: second sync byte); write only while idle.
// Output path: the result of an accepted byte is registered in the output
// register, or in the skid entry when that register is held. Throughput: one byte
// per cycle while in_stall is low; parsing and checksum update are combinational ahead of the output register.
// Receiver stall: the output register holds its item, and one more item is
// taken into a skid entry; in_stall rises only once that entry is full.
// Reset: sync registers, frame state and checksums clear; both buffers empty.
module log_packet_deframer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ldf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ldf_pkg::BYTE_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ldf_pkg::BYTE_W-1:0]    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          payload_valid,
    output logic [ldf_pkg::BYTE_W-1:0]    payload_byte,
    output logic [ldf_pkg::LEN_W-1:0]     payload_index,
    output logic [ldf_pkg::BYTE_W-1:0]    frame_type,
    output logic [ldf_pkg::LEN_W-1:0]     frame_length,
    output logic                          frame_good,
    output logic                          frame_bad
);
    import ldf_pkg::*;

    logic        accept;
    logic        buf_full;
    ldf_result_t parse_res;
    ldf_result_t out_res;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    ldf_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .result    (parse_res)
    );

    ldf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .din       (parse_res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dout      (out_res)
    );

    assign payload_valid = out_res.payload_valid;
    assign payload_byte  = out_res.payload_byte;
    assign payload_index = out_res.payload_index;
    assign frame_type    = out_res.frame_type;
    assign frame_length  = out_res.frame_length;
    assign frame_good    = out_res.frame_good;
    assign frame_bad     = out_res.frame_bad;

endmodule

// ----- hw/rtl/ldf_parser.sv -----
// Frame parser: sync registers, frame position and Fletcher sums; builds one
// result per accepted byte. Depends on ldf_pkg.
module ldf_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ldf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ldf_pkg::BYTE_W-1:0]     cfg_data,
    input  logic                           accept,
    input  logic [ldf_pkg::BYTE_W-1:0]     rx_byte,
    output ldf_pkg::ldf_result_t           result
);
    import ldf_pkg::*;

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [POS_W-1:0]  position_reg, position_next;
    logic [LEN_W-1:0]  decl_len_reg, decl_len_next;
    logic [BYTE_W-1:0] len_low_reg, len_low_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;

    logic [BYTE_W-1:0] acc_a;
    logic [BYTE_W-1:0] acc_b;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  payload_off;
    logic              finish;

    always_comb
    begin
        acc_a         = sum_a_reg + rx_byte;
        acc_b         = sum_b_reg + acc_a;
        end_pos       = POS_W'(decl_len_reg) + POS_HEADER_END;
        payload_off   = position_reg - POS_HEADER_END;
        position_next = position_reg;
        decl_len_next = decl_len_reg;
        len_low_next  = len_low_reg;
        type_next     = type_reg;
        sum_a_next    = sum_a_reg;
        sum_b_next    = sum_b_reg;
        finish        = 1'b0;
        result        = '0;

        if (position_reg == POS_SYNC_FIRST)
        begin
            if (rx_byte == sync_first_reg)
            begin
                sum_a_next    = acc_a;
                sum_b_next    = acc_b;
                position_next = POS_SYNC_SECOND;
            end
        end
        else if (position_reg == POS_SYNC_SECOND)
        begin
            if (rx_byte == sync_second_reg)
            begin
                sum_a_next    = acc_a;
                sum_b_next    = acc_b;
                position_next = POS_TYPE;
            end
        end
        else if (position_reg == POS_TYPE)
        begin
            type_next     = rx_byte;
            sum_a_next    = acc_a;
            sum_b_next    = acc_b;
            position_next = POS_LEN_LOW;
        end
        else if (position_reg == POS_LEN_LOW)
        begin
            len_low_next  = rx_byte;
            sum_a_next    = acc_a;
            sum_b_next    = acc_b;
            position_next = POS_LEN_HIGH;
        end
        else if (position_reg == POS_LEN_HIGH)
        begin
            decl_len_next = {rx_byte, len_low_reg};
            sum_a_next    = acc_a;
            sum_b_next    = acc_b;
            position_next = POS_HEADER_END;
        end
        else if (position_reg < end_pos)
        begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = payload_off[LEN_W-1:0];
            sum_a_next           = acc_a;
            sum_b_next           = acc_b;
            position_next        = position_reg + POS_W'(1);
        end
        else if (position_reg == end_pos)
        begin
            if (rx_byte == sum_a_reg)
            begin
                position_next = position_reg + POS_W'(1);
            end
            else
            begin
                result.frame_bad = 1'b1;
                finish           = 1'b1;
            end
        end
        else
        begin
            result.frame_good = (rx_byte == sum_b_reg);
            result.frame_bad  = (rx_byte != sum_b_reg);
            finish            = 1'b1;
        end

        result.frame_type   = type_next;
        result.frame_length = decl_len_next;

        if (finish)
        begin
            position_next = '0;
            decl_len_next = '0;
            len_low_next  = '0;
            type_next     = '0;
            sum_a_next    = '0;
            sum_b_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= '0;
            sync_second_reg <= '0;
            position_reg    <= '0;
            decl_len_reg    <= '0;
            len_low_reg     <= '0;
            type_reg        <= '0;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_SYNC_FIRST)
            begin
                sync_first_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_SYNC_SECOND)
            begin
                sync_second_reg <= cfg_data;
            end
            if (accept)
            begin
                position_reg <= position_next;
                decl_len_reg <= decl_len_next;
                len_low_reg  <= len_low_next;
                type_reg     <= type_next;
                sum_a_reg    <= sum_a_next;
                sum_b_reg    <= sum_b_next;
            end
        end
    end

endmodule

// ----- hw/rtl/ldf_out_buf.sv -----
// Output register with one skid entry; input side stalls only when the skid
// entry is occupied. Depends on ldf_pkg.
module ldf_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  ldf_pkg::ldf_result_t  din,
    output logic                  full,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ldf_pkg::ldf_result_t  dout
);
    import ldf_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    ldf_result_t main_reg;
    ldf_result_t skid_reg;
    logic        take;

    assign take      = main_valid_reg && !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign dout      = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!main_valid_reg || take)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            main_valid_reg <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!main_valid_reg || take)
            begin
                main_reg <= din;
            end
            else
            begin
                skid_reg <= din;
            end
        end
        else if (take && skid_valid_reg)
        begin
            main_reg <= skid_reg;
        end
    end

endmodule

// ----- hw/rtl/ldf_checker.sv -----
// Port-level checks for the log packet deframer, bound to the top level.
// Depends on ldf_pkg and log_packet_deframer.
module ldf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          payload_valid,
    input  logic [ldf_pkg::LEN_W-1:0]     payload_index,
    input  logic [ldf_pkg::LEN_W-1:0]     frame_length,
    input  logic                          frame_good,
    input  logic                          frame_bad
);
    import ldf_pkg::*;

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after accepted item");

    a_verdict_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (payload_valid || frame_good) |-> !frame_bad)
        else $error("bad verdict on payload or good item");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> payload_index < frame_length)
        else $error("payload index beyond frame length");

endmodule

bind log_packet_deframer ldf_checker u_ldf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .payload_valid (payload_valid),
    .payload_index (payload_index),
    .frame_length  (frame_length),
    .frame_good    (frame_good),
    .frame_bad     (frame_bad)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for log_packet_deframer: random and directed byte streams with framed
// packets, checked item by item against a built-in model of the deframer.
// Depends on ldf_pkg and the log_packet_deframer RTL.
module tb_top;
    import ldf_pkg::*;

    typedef enum {FLAW_NONE, FLAW_CHECK_A, FLAW_CHECK_B} flaw_t;

    localparam int unsigned QUIET_LIMIT = 1000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam int unsigned PHASE_BYTES = 250;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SYNC_FIRST;
    logic [BYTE_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 payload_valid;
    logic [BYTE_W-1:0]    payload_byte;
    logic [LEN_W-1:0]     payload_index;
    logic [BYTE_W-1:0]    frame_type;
    logic [LEN_W-1:0]     frame_length;
    logic                 frame_good;
    logic                 frame_bad;

    log_packet_deframer dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .payload_valid(payload_valid),
        .payload_byte(payload_byte),
        .payload_index(payload_index),
        .frame_type(frame_type),
        .frame_length(frame_length),
        .frame_good(frame_good),
        .frame_bad(frame_bad)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [BYTE_W-1:0] tx_bytes[$];
    ldf_result_t       pending_results[$];
    logic              in_fired = 1'b0;
    logic              tx_idle_on = 1'b1;
    logic              rx_idle_on = 1'b1;
    int unsigned       hold_asked = 0;
    int unsigned       err_cnt = 0;

    // deframer model state and its copy of the sync registers
    logic [BYTE_W-1:0] exp_sync_first = '0;
    logic [BYTE_W-1:0] exp_sync_second = '0;
    logic [POS_W-1:0]  frm_pos = '0;
    logic [LEN_W-1:0]  frm_len = '0;
    logic [BYTE_W-1:0] frm_len_lo = '0;
    logic [BYTE_W-1:0] frm_type = '0;
    logic [BYTE_W-1:0] run_a = '0;
    logic [BYTE_W-1:0] run_b = '0;

    // stream builder state
    logic [BYTE_W-1:0] cur_first = '0;
    logic [BYTE_W-1:0] cur_second = '0;
    logic [BYTE_W-1:0] frame_sa;
    logic [BYTE_W-1:0] frame_sb;
    int unsigned       stim_bytes;
    logic [BYTE_W-1:0] ph_first[6];
    logic [BYTE_W-1:0] ph_second[6];

    function automatic int pick_gap(input logic en);
        int unsigned r;
        r = $urandom_range(99);
        if (!en || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] rand_except(input logic [BYTE_W-1:0] x);
        logic [BYTE_W-1:0] v;
        v = 8'($urandom);
        while (v == x)
            v = 8'($urandom);
        return v;
    endfunction

    task automatic fold_sum(input logic [BYTE_W-1:0] b);
        run_a = run_a + b;
        run_b = run_b + run_a;
    endtask

    task automatic tx_add(input logic [BYTE_W-1:0] b);
        tx_bytes.insert(tx_bytes.size(), b);
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b, output ldf_result_t r);
        logic [POS_W-1:0] end_pos;
        logic             done;
        end_pos = POS_W'(frm_len) + POS_HEADER_END;
        done = 1'b0;
        r = '0;
        if (frm_pos == POS_SYNC_FIRST)
        begin
            if (b == exp_sync_first)
            begin
                fold_sum(b);
                frm_pos = POS_SYNC_SECOND;
            end
        end
        else if (frm_pos == POS_SYNC_SECOND)
        begin
            if (b == exp_sync_second)
            begin
                fold_sum(b);
                frm_pos = POS_TYPE;
            end
        end
        else if (frm_pos == POS_TYPE)
        begin
            frm_type = b;
            fold_sum(b);
            frm_pos = POS_LEN_LOW;
        end
        else if (frm_pos == POS_LEN_LOW)
        begin
            frm_len_lo = b;
            fold_sum(b);
            frm_pos = POS_LEN_HIGH;
        end
        else if (frm_pos == POS_LEN_HIGH)
        begin
            frm_len = {b, frm_len_lo};
            fold_sum(b);
            frm_pos = POS_HEADER_END;
        end
        else if (frm_pos < end_pos)
        begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.payload_index = LEN_W'(frm_pos - POS_HEADER_END);
            fold_sum(b);
            frm_pos = frm_pos + POS_W'(1);
        end
        else if (frm_pos == end_pos)
        begin
            if (b == run_a)
                frm_pos = frm_pos + POS_W'(1);
            else
            begin
                r.frame_bad = 1'b1;
                done = 1'b1;
            end
        end
        else
        begin
            if (b == run_b)
                r.frame_good = 1'b1;
            else
                r.frame_bad = 1'b1;
            done = 1'b1;
        end
        r.frame_type = frm_type;
        r.frame_length = frm_len;
        if (done)
        begin
            frm_pos = '0;
            frm_len = '0;
            frm_len_lo = '0;
            frm_type = '0;
            run_a = '0;
            run_b = '0;
        end
    endtask

    // sender
    int tx_gap = 0;
    always @(negedge clk)
    begin
        if (!in_valid || in_fired)
        begin
            if (tx_gap != 0)
            begin
                in_valid <= 1'b0;
                tx_gap = tx_gap - 1;
            end
            else if (tx_bytes.size() != 0)
            begin
                in_valid <= 1'b1;
                rx_byte <= tx_bytes[0];
                tx_gap = pick_gap(tx_idle_on);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    int          rx_gap = 0;
    int unsigned hold_cnt = 0;
    int unsigned hold_taken = 0;
    always @(negedge clk)
    begin
        if (hold_cnt != 0)
        begin
            out_stall <= 1'b1;
            hold_cnt = hold_cnt - 1;
        end
        else if (hold_taken != hold_asked)
        begin
            hold_taken = hold_taken + 1;
            hold_cnt = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (rx_gap != 0)
        begin
            out_stall <= 1'b1;
            rx_gap = rx_gap - 1;
        end
        else
        begin
            rx_gap = pick_gap(rx_idle_on);
            if (rx_gap != 0)
            begin
                out_stall <= 1'b1;
                rx_gap = rx_gap - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // monitor, model and watchdog
    int unsigned quiet_cycles = 0;
    always @(posedge clk)
    begin
        ldf_result_t got;
        ldf_result_t want;
        in_fired <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SYNC_FIRST)
                    exp_sync_first = cfg_data;
                else if (cfg_index == CFG_SYNC_SECOND)
                    exp_sync_second = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got.payload_valid = payload_valid;
                got.payload_byte = payload_byte;
                got.payload_index = payload_index;
                got.frame_type = frame_type;
                got.frame_length = frame_length;
                got.frame_good = frame_good;
                got.frame_bad = frame_bad;
                if (pending_results.size() == 0)
                begin
                    $error("result item with no expectation pending");
                    err_cnt++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.payload_valid !== want.payload_valid)
                    begin
                        $error("payload_valid: expected %0d, got %0d",
                               want.payload_valid, got.payload_valid);
                        err_cnt++;
                    end
                    if (got.payload_byte !== want.payload_byte)
                    begin
                        $error("payload_byte: expected %0h, got %0h",
                               want.payload_byte, got.payload_byte);
                        err_cnt++;
                    end
                    if (got.payload_index !== want.payload_index)
                    begin
                        $error("payload_index: expected %0d, got %0d",
                               want.payload_index, got.payload_index);
                        err_cnt++;
                    end
                    if (got.frame_type !== want.frame_type)
                    begin
                        $error("frame_type: expected %0h, got %0h",
                               want.frame_type, got.frame_type);
                        err_cnt++;
                    end
                    if (got.frame_length !== want.frame_length)
                    begin
                        $error("frame_length: expected %0d, got %0d",
                               want.frame_length, got.frame_length);
                        err_cnt++;
                    end
                    if (got.frame_good !== want.frame_good)
                    begin
                        $error("frame_good: expected %0d, got %0d",
                               want.frame_good, got.frame_good);
                        err_cnt++;
                    end
                    if (got.frame_bad !== want.frame_bad)
                    begin
                        $error("frame_bad: expected %0d, got %0d",
                               want.frame_bad, got.frame_bad);
                        err_cnt++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                deframe_byte(rx_byte, want);
                pending_results.insert(pending_results.size(), want);
                void'(tx_bytes.pop_front());
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic put_framed(input logic [BYTE_W-1:0] b);
        tx_add(b);
        frame_sa = frame_sa + b;
        frame_sb = frame_sb + frame_sa;
        stim_bytes++;
    endtask

    task automatic queue_frame(input logic [BYTE_W-1:0] typ, input int len,
                               input flaw_t flaw, input int junk);
        frame_sa = '0;
        frame_sb = '0;
        put_framed(cur_first);
        repeat (junk)
            tx_add(rand_except(cur_second));
        put_framed(cur_second);
        put_framed(typ);
        put_framed(len[7:0]);
        put_framed(len[15:8]);
        repeat (len)
            put_framed(8'($urandom));
        case (flaw)
            FLAW_CHECK_A:
            begin
                tx_add(frame_sa ^ 8'($urandom_range(1, 255)));
            end
            FLAW_CHECK_B:
            begin
                tx_add(frame_sa);
                tx_add(frame_sb ^ 8'($urandom_range(1, 255)));
            end
            default:
            begin
                tx_add(frame_sa);
                tx_add(frame_sb);
            end
        endcase
        stim_bytes += 2;
    endtask

    task automatic drain_all();
        while (tx_bytes.size() != 0 || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_sync(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data <= first;
        @(negedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data <= second;
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_first = first;
        cur_second = second;
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned fpick;
        int          flen;
        flaw_t       flaw;
        ph_first  = '{8'hFF, 8'h00, 8'hFF, 8'hB5, 8'h00, 8'h00};
        ph_second = '{8'h00, 8'hFF, 8'hFF, 8'h62, 8'h00, 8'h00};
        ph_first[4] = 8'($urandom);
        ph_second[4] = 8'($urandom);
        ph_first[5] = 8'($urandom);
        ph_second[5] = ph_first[5];

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: sync values at reset, stray bytes, zero length, both check failures
        tx_add(8'h07);
        queue_frame(8'hFF, 0, FLAW_NONE, 1);
        queue_frame(8'h00, 2, FLAW_CHECK_A, 0);
        queue_frame(8'h80, 1, FLAW_CHECK_B, 0);
        drain_all();

        for (int ph = 0; ph < 6; ph++)
        begin
            set_sync(ph_first[ph], ph_second[ph]);
            tx_idle_on = (ph != 2);
            rx_idle_on = (ph != 2);
            @(posedge clk);
            stim_bytes = 0;
            if (ph == 3)
                queue_frame(8'($urandom), 300, FLAW_NONE, 0);
            while (stim_bytes < PHASE_BYTES)
            begin
                pick = $urandom_range(99);
                if (pick < 10)
                    repeat ($urandom_range(1, 3))
                        tx_add(rand_except(cur_first));
                flen = ($urandom_range(9) < 8) ? $urandom_range(8) : $urandom_range(9, 40);
                fpick = $urandom_range(99);
                flaw = (fpick < 70) ? FLAW_NONE : (fpick < 85) ? FLAW_CHECK_A : FLAW_CHECK_B;
                queue_frame(8'($urandom), flen, flaw,
                            (pick >= 10 && pick < 16) ? $urandom_range(1, 2) : 0);
            end
            if (ph == 1)
                hold_asked++;
            drain_all();
        end

        // largest declared length: header and the start of its payload only
        frame_sa = '0;
        frame_sb = '0;
        put_framed(cur_first);
        put_framed(cur_second);
        put_framed(8'($urandom));
        put_framed(8'hFF);
        put_framed(8'hFF);
        repeat (40)
            put_framed(8'($urandom));
        drain_all();
        repeat (10) @(posedge clk);

        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
